@@ sv/mcdc_pkg.sv @@
// Shared types and constants of the multi-coil dwell controller.
package mcdc_pkg;

    localparam logic [31:0] DEFAULT_DWELL_LIMIT = 32'd10000;
    localparam logic [3:0]  RESET_COIL_COUNT    = 4'd8;
    localparam int          IN_DATA_W           = 40;
    localparam int          OUT_DATA_W          = 280;

    // Register byte addresses on the configuration port.
    localparam logic [3:0] ADDR_COIL_COUNT    = 4'h0;
    localparam logic [3:0] ADDR_DWELL_LIMIT   = 4'h4;
    localparam logic [3:0] ADDR_POLARITY_MASK = 4'h8;

    typedef enum logic [2:0] {
        REQ_CHARGE    = 3'd0,
        REQ_FIRE      = 3'd1,
        REQ_TICK      = 3'd2,
        REQ_ENABLE    = 3'd3,
        REQ_SHUTDOWN  = 3'd4,
        REQ_RST_STATS = 3'd5,
        REQ_QUERY     = 3'd6
    } req_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_READ
    } state_t;

    typedef struct packed {
        logic [3:0]  coil_count;
        logic [31:0] dwell_limit;
        logic [7:0]  polarity_mask;
    } cfg_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;
        logic sweep;
        logic finish;
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic last_slot;
    } status_t;

    // Result layout, last field in the lowest bits.
    typedef struct packed {
        logic [3:0]  pad;
        logic [31:0] last_spark_time;
        logic [31:0] last_charge_start;
        logic [31:0] current_dwell;
        logic [31:0] all_sparks;
        logic [31:0] peak_dwell;
        logic [31:0] last_dwell;
        logic [31:0] dwell_sum;
        logic [31:0] spark_count;
        logic [2:0]  over_dwell_coil;
        logic        over_dwell_found;
        logic [7:0]  charging_mask;
        logic [7:0]  drive_levels;
    } result_t;

endpackage

@@ sv/mcdc_regs.sv @@
// Configuration registers behind the APB-style port.
module mcdc_regs (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output mcdc_pkg::cfg_t     cfg
);

    mcdc_pkg::cfg_t cfg_reg;
    mcdc_pkg::cfg_t cfg_next;
    logic           wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (paddr)
                mcdc_pkg::ADDR_COIL_COUNT: begin
                    cfg_next.coil_count = pwdata[3:0];
                end
                mcdc_pkg::ADDR_DWELL_LIMIT: begin
                    // A zero limit falls back to the default.
                    cfg_next.dwell_limit = (pwdata == 32'd0) ?
                        mcdc_pkg::DEFAULT_DWELL_LIMIT : pwdata;
                end
                mcdc_pkg::ADDR_POLARITY_MASK: begin
                    cfg_next.polarity_mask = pwdata[7:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.coil_count    <= mcdc_pkg::RESET_COIL_COUNT;
            cfg_reg.dwell_limit   <= mcdc_pkg::DEFAULT_DWELL_LIMIT;
            cfg_reg.polarity_mask <= 8'd0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        case (paddr)
            mcdc_pkg::ADDR_COIL_COUNT:    prdata = {28'd0, cfg_reg.coil_count};
            mcdc_pkg::ADDR_DWELL_LIMIT:   prdata = cfg_reg.dwell_limit;
            mcdc_pkg::ADDR_POLARITY_MASK: prdata = {24'd0, cfg_reg.polarity_mask};
            default:                      prdata = 32'd0;
        endcase
    end

endmodule

@@ sv/mcdc_ctrl.sv @@
// Sequencer that steps one request through the slot sweep and result load.
module mcdc_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output mcdc_pkg::cmd_t      cmd,
    input  mcdc_pkg::status_t   status
);

    mcdc_pkg::state_t state_reg;
    mcdc_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_free;

    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mcdc_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = mcdc_pkg::ST_SWEEP;
                end
            end
            mcdc_pkg::ST_SWEEP: begin
                if (status.last_slot) begin
                    state_next = mcdc_pkg::ST_READ;
                end
            end
            mcdc_pkg::ST_READ: begin
                if (out_free) begin
                    state_next = mcdc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mcdc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready   = 1'b0;
        cmd.load   = 1'b0;
        cmd.sweep  = 1'b0;
        cmd.finish = 1'b0;
        case (state_reg)
            mcdc_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            mcdc_pkg::ST_SWEEP: begin
                cmd.sweep = 1'b1;
            end
            mcdc_pkg::ST_READ: begin
                cmd.finish = out_free;
            end
            default: begin
            end
        endcase
    end

    // The result register is emptied independently of the sequencer.
    always_comb begin
        if (cmd.finish) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_tvalid = out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= mcdc_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_accept_starts_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> state_reg == mcdc_pkg::ST_SWEEP)
        else $error("accepted transaction did not start the slot sweep");

    a_finish_into_free_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> (!out_valid_reg || m_tready))
        else $error("result loaded over an untaken transaction");

    a_result_follows_read: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == mcdc_pkg::ST_READ))
        else $error("result appeared without a read step");

    a_sweep_ends_in_read: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == mcdc_pkg::ST_SWEEP && status.last_slot
        |=> state_reg == mcdc_pkg::ST_READ)
        else $error("sweep end did not lead to the read step");

endmodule

@@ sv/mcdc_datapath.sv @@
// Per-coil state file, slot sweep arithmetic and result register.
module mcdc_datapath #(
    parameter int COIL_SLOTS = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  mcdc_pkg::cmd_t      cmd,
    output mcdc_pkg::status_t   status,
    input  mcdc_pkg::cfg_t      cfg,
    input  logic [2:0]          in_req_type,
    input  logic [2:0]          in_coil,
    input  logic [31:0]         in_timestamp,
    input  logic                in_enable_value,
    output mcdc_pkg::result_t   result
);

    localparam int IDX_W = (COIL_SLOTS > 1) ? $clog2(COIL_SLOTS) : 1;
    localparam int N_W   = $clog2(COIL_SLOTS + 1);
    localparam int CMP_W = (N_W > 4) ? N_W : 4;

    // Captured request.
    logic [2:0]  req_reg;
    logic [2:0]  coil_reg;
    logic [31:0] ts_reg;
    logic        en_reg;

    // Sweep bookkeeping.
    logic [IDX_W-1:0] cnt_reg;
    logic [IDX_W-1:0] cnt_next;
    logic             found_reg;
    logic             found_next;
    logic [2:0]       fcoil_reg;
    logic [2:0]       fcoil_next;
    logic [31:0]      sum_reg;
    logic [31:0]      sum_next;

    // Per-coil state.
    logic [COIL_SLOTS-1:0] enabled_reg;
    logic [COIL_SLOTS-1:0] enabled_next;
    logic [COIL_SLOTS-1:0] charging_reg;
    logic [COIL_SLOTS-1:0] charging_next;
    logic [31:0] start_reg  [COIL_SLOTS];
    logic [31:0] sparks_reg [COIL_SLOTS];
    logic [31:0] total_reg  [COIL_SLOTS];
    logic [31:0] last_reg   [COIL_SLOTS];
    logic [31:0] peak_reg   [COIL_SLOTS];
    logic [31:0] sstart_reg [COIL_SLOTS];
    logic [31:0] sfire_reg  [COIL_SLOTS];

    // Next values of the entry at the current index.
    logic [31:0] start_next;
    logic [31:0] sparks_next;
    logic [31:0] total_next;
    logic [31:0] last_next;
    logic [31:0] peak_next;
    logic [31:0] sstart_next;
    logic [31:0] sfire_next;

    logic [IDX_W-1:0] idx;
    logic [CMP_W-1:0] n_use;
    logic [CMP_W-1:0] cnt_ext;
    logic [CMP_W-1:0] coil_ext;
    logic [31:0]      rd_start;
    logic [31:0]      rd_sparks;
    logic [31:0]      dwell;
    logic             start_nz;
    logic             in_use;
    logic             coil_ok;
    logic             hit_c;
    logic             tick_hit;
    logic             fire_go;
    logic             fire_eff;
    logic             record;
    logic             clear_stats;
    logic [7:0]       mask8;

    assign n_use = (CMP_W'(cfg.coil_count) > CMP_W'(COIL_SLOTS)) ?
                   CMP_W'(COIL_SLOTS) : CMP_W'(cfg.coil_count);
    assign cnt_ext  = CMP_W'(cnt_reg);
    assign coil_ext = CMP_W'(coil_reg);
    assign coil_ok  = coil_ext < n_use;
    assign in_use   = cnt_ext < n_use;
    assign hit_c    = coil_ok && (cnt_ext == coil_ext);

    // The sweep walks the slots; the read step looks at the requested coil.
    assign idx = cmd.sweep ? cnt_reg : IDX_W'(coil_reg);

    assign rd_start  = start_reg[idx];
    assign rd_sparks = sparks_reg[idx];
    assign dwell     = ts_reg - rd_start;
    assign start_nz  = rd_start != 32'd0;

    assign status.last_slot = cnt_reg == IDX_W'(COIL_SLOTS - 1);

    // Only the lowest over-dwell coil fires on a tick.
    assign tick_hit = (req_reg == mcdc_pkg::REQ_TICK) && !found_reg && in_use &&
                      charging_reg[idx] && start_nz && (dwell > cfg.dwell_limit);
    assign fire_go  = ((req_reg == mcdc_pkg::REQ_FIRE) && hit_c) || tick_hit;
    assign fire_eff = fire_go && enabled_reg[idx];
    assign record   = fire_eff && start_nz;
    assign clear_stats = (req_reg == mcdc_pkg::REQ_RST_STATS) && in_use;

    always_comb begin
        enabled_next  = enabled_reg;
        charging_next = charging_reg;
        start_next    = rd_start;
        sparks_next   = rd_sparks;
        total_next    = total_reg[idx];
        last_next     = last_reg[idx];
        peak_next     = peak_reg[idx];
        sstart_next   = sstart_reg[idx];
        sfire_next    = sfire_reg[idx];
        found_next    = found_reg;
        fcoil_next    = fcoil_reg;
        sum_next      = sum_reg;
        cnt_next      = cnt_reg;

        if (cmd.load) begin
            cnt_next   = '0;
            found_next = 1'b0;
            fcoil_next = 3'd0;
            sum_next   = 32'd0;
        end else if (cmd.sweep) begin
            cnt_next = cnt_reg + IDX_W'(1);
            case (req_reg)
                mcdc_pkg::REQ_CHARGE: begin
                    if (hit_c && enabled_reg[idx] && !charging_reg[idx]) begin
                        charging_next[idx] = 1'b1;
                        start_next         = ts_reg;
                    end
                end
                mcdc_pkg::REQ_ENABLE: begin
                    if (hit_c) begin
                        enabled_next[idx] = en_reg;
                        if (!en_reg) begin
                            charging_next[idx] = 1'b0;
                        end
                    end
                end
                mcdc_pkg::REQ_SHUTDOWN: begin
                    if (in_use && enabled_reg[idx]) begin
                        charging_next[idx] = 1'b0;
                    end
                end
                default: begin
                end
            endcase

            if (fire_eff) begin
                charging_next[idx] = 1'b0;
            end
            if (record) begin
                sparks_next = rd_sparks + 32'd1;
                total_next  = total_reg[idx] + dwell;
                last_next   = dwell;
                sstart_next = rd_start;
                sfire_next  = ts_reg;
                if (dwell > peak_reg[idx]) begin
                    peak_next = dwell;
                end
            end
            if (clear_stats) begin
                sparks_next = 32'd0;
                total_next  = 32'd0;
                last_next   = 32'd0;
                peak_next   = 32'd0;
                sstart_next = 32'd0;
                sfire_next  = 32'd0;
            end
            if (tick_hit) begin
                found_next = 1'b1;
                fcoil_next = 3'(idx);
            end
            // The spark total sees each count after this slot's update.
            if (in_use && !clear_stats) begin
                sum_next = sum_reg + rd_sparks + {31'd0, record};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg  <= in_req_type;
            coil_reg <= in_coil;
            ts_reg   <= in_timestamp;
            en_reg   <= in_enable_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            found_reg    <= 1'b0;
            fcoil_reg    <= 3'd0;
            sum_reg      <= 32'd0;
            enabled_reg  <= '0;
            charging_reg <= '0;
            for (int i = 0; i < COIL_SLOTS; i++) begin
                start_reg[i]  <= 32'd0;
                sparks_reg[i] <= 32'd0;
                total_reg[i]  <= 32'd0;
                last_reg[i]   <= 32'd0;
                peak_reg[i]   <= 32'd0;
                sstart_reg[i] <= 32'd0;
                sfire_reg[i]  <= 32'd0;
            end
        end else begin
            cnt_reg      <= cnt_next;
            found_reg    <= found_next;
            fcoil_reg    <= fcoil_next;
            sum_reg      <= sum_next;
            enabled_reg  <= enabled_next;
            charging_reg <= charging_next;
            if (cmd.sweep) begin
                start_reg[idx]  <= start_next;
                sparks_reg[idx] <= sparks_next;
                total_reg[idx]  <= total_next;
                last_reg[idx]   <= last_next;
                peak_reg[idx]   <= peak_next;
                sstart_reg[idx] <= sstart_next;
                sfire_reg[idx]  <= sfire_next;
            end
        end
    end

    // Slots numbered eight or higher never show in the byte-wide masks.
    for (genvar k = 0; k < 8; k++) begin : g_mask
        if (k < COIL_SLOTS) begin : g_slot
            assign mask8[k] = charging_reg[k];
        end else begin : g_none
            assign mask8[k] = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            result.pad              <= 4'd0;
            result.drive_levels     <= mask8 ^ cfg.polarity_mask;
            result.charging_mask    <= mask8;
            result.over_dwell_found <= found_reg;
            result.over_dwell_coil  <= fcoil_reg;
            result.all_sparks       <= sum_reg;
            result.spark_count       <= coil_ok ? rd_sparks : 32'd0;
            result.dwell_sum         <= coil_ok ? total_reg[idx] : 32'd0;
            result.last_dwell        <= coil_ok ? last_reg[idx] : 32'd0;
            result.peak_dwell        <= coil_ok ? peak_reg[idx] : 32'd0;
            result.last_charge_start <= coil_ok ? sstart_reg[idx] : 32'd0;
            result.last_spark_time   <= coil_ok ? sfire_reg[idx] : 32'd0;
            result.current_dwell     <= (coil_ok && charging_reg[idx] && start_nz) ?
                                        dwell : 32'd0;
        end
    end

endmodule

@@ sv/multi_coil_dwell_controller.sv @@
// Top level of the multi-coil ignition dwell controller.
//
//  Channel   Direction  Handshake          Carries
//  s_        in         s_tvalid/s_tready  one request (kind in tuser)
//  m_        out        m_tvalid/m_tready  one status and statistics result
//  APB       in/out     psel/penable       coil_count, dwell_limit, polarity_mask
//
// A request passes through the acceptance cycle, a sweep that visits each coil slot
// in turn through the per-coil state, and a read step for the requested coil, at
// whose end the result register is loaded.
// The next request is taken in the cycle after the result is loaded, even
// while that result still waits on m_tready; a full result register holds
// the read step. Reset clears all coil state at once, with no clearing pass.
module multi_coil_dwell_controller #(
    parameter int COIL_SLOTS = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    // Request transaction.
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [mcdc_pkg::IN_DATA_W-1:0]  s_tdata,  // coil[2:0], timestamp[34:3],
                                                      // enable_value[35]
    input  logic [2:0]   s_tuser,   // req_type[2:0]
    // Result transaction.
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [mcdc_pkg::OUT_DATA_W-1:0] m_tdata,  // drive_levels, charging_mask,
                                    // over_dwell_found, over_dwell_coil, spark_count,
                                    // dwell_sum, last_dwell, peak_dwell, all_sparks,
                                    // current_dwell, last_charge_start,
                                    // last_spark_time, from bit 0 up
    // Configuration port.
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    mcdc_pkg::cfg_t    cfg;
    mcdc_pkg::cmd_t    cmd;
    mcdc_pkg::status_t status;
    mcdc_pkg::result_t result;

    mcdc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mcdc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    mcdc_datapath #(
        .COIL_SLOTS (COIL_SLOTS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .cfg             (cfg),
        .in_req_type     (s_tuser),
        .in_coil         (s_tdata[2:0]),
        .in_timestamp    (s_tdata[34:3]),
        .in_enable_value (s_tdata[35]),
        .result          (result)
    );

    assign m_tdata = result;

endmodule
